[rtl/mm4_pkg.sv]
// ----------------------------------------------------------------------------
// mm4_pkg
// Shared types and constants for the fixed-point matrix multiply block.
// ----------------------------------------------------------------------------
`default_nettype none

package mm4_pkg;

   localparam int DIM_DEFAULT       = 4;
   localparam int FRAC_BITS_DEFAULT = 16;
   localparam int ELEM_W            = 32;
   localparam int IDX_FIELD_W       = 2;
   localparam int PROD_W            = 2 * ELEM_W;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0]   load_row;
      logic [IDX_FIELD_W-1:0]   load_col;
      logic signed [ELEM_W-1:0] a_element;
      logic signed [ELEM_W-1:0] b_element;
      logic                     go;
   } req_type;

   typedef struct packed {
      logic [IDX_FIELD_W-1:0]   out_row;
      logic [IDX_FIELD_W-1:0]   out_col;
      logic signed [ELEM_W-1:0] product_value;
      logic                     last_out;
   } rsp_type;

   // travels with each multiply-accumulate beat down the datapath
   typedef struct packed {
      logic                   valid;
      logic                   first;
      logic                   acc_end;
      logic                   last;
      logic [IDX_FIELD_W-1:0] row;
      logic [IDX_FIELD_W-1:0] col;
   } tag_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

endpackage

`default_nettype wire

[rtl/matrix4x4_multiply.sv]
// ----------------------------------------------------------------------------
// matrix4x4_multiply
// Signed fixed-point DIM x DIM matrix product on one shared MAC unit.
// ----------------------------------------------------------------------------
// Usage:
//  - each beat on start/req_item (taken when busy is low) writes one element of
//    the left and right matrices at (load_row, load_col); indices at or beyond
//    DIM write nothing. A load without go leaves busy low.
//  - a beat with go stores its element and then multiplies the stored
//    matrices. busy rises for the whole multiply and no beat is taken.
//  - the MAC does one product per cycle, so a multiply issues DIM^3 beats;
//    results leave on rsp_valid/rsp_item in row-major order, one per output
//    element, the last flagged last_out. busy falls after the last result.
//  - each product is exact, sums are full width, then shifted right by
//    FRAC_BITS (toward minus infinity) and saturated to 32 bits.
//  - rsp_valid is high for one cycle per result; the receiver must take it.
//  - reset clears the sequencer and pipeline valids; store contents are
//    undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix4x4_multiply #(
   parameter int DIM       = mm4_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire mm4_pkg::req_type req_item,
   output logic                  busy,
   output logic                  rsp_valid,
   output mm4_pkg::rsp_type      rsp_item
);
   import mm4_pkg::*;

   localparam int ADDR_W = $clog2(DIM * DIM);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_a_addr, rd_b_addr;
   logic [ELEM_W-1:0] rd_a_data, rd_b_data;
   tag_type           tag_issue;

   mm4_ctrl #(
      .DIM    (DIM),
      .ADDR_W (ADDR_W)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_item.last_out),
      .busy      (busy),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .tag_issue (tag_issue)
   );

   mm4_store #(
      .DIM    (DIM),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_a      (req_item.a_element),
      .wr_b      (req_item.b_element),
      .rd_a_addr (rd_a_addr),
      .rd_b_addr (rd_b_addr),
      .rd_a_data (rd_a_data),
      .rd_b_data (rd_b_data)
   );

   mm4_mac #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS)
   ) u_mac (
      .clock     (clock),
      .reset     (reset),
      .tag_issue (tag_issue),
      .a_data    (rd_a_data),
      .b_data    (rd_b_data),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

[rtl/mm4_store.sv]
// ----------------------------------------------------------------------------
// mm4_store
// Element stores for the left and right matrices, one write port shared by
// both, one registered read port each.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_store #(
   parameter int DIM    = mm4_pkg::DIM_DEFAULT,
   parameter int ADDR_W = $clog2(DIM * DIM)
) (
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [ADDR_W-1:0]         wr_addr,
   input  wire logic [mm4_pkg::ELEM_W-1:0] wr_a,
   input  wire logic [mm4_pkg::ELEM_W-1:0] wr_b,
   input  wire logic [ADDR_W-1:0]         rd_a_addr,
   input  wire logic [ADDR_W-1:0]         rd_b_addr,
   output logic      [mm4_pkg::ELEM_W-1:0] rd_a_data,
   output logic      [mm4_pkg::ELEM_W-1:0] rd_b_data
);
   import mm4_pkg::*;

   localparam int DEPTH = DIM * DIM;

   logic [ELEM_W-1:0] left_mem  [DEPTH];
   logic [ELEM_W-1:0] right_mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         left_mem[wr_addr]  <= wr_a;
         right_mem[wr_addr] <= wr_b;
      end
   end

   always_ff @(posedge clock) begin
      rd_a_data <= left_mem[rd_a_addr];
      rd_b_data <= right_mem[rd_b_addr];
   end

endmodule

`default_nettype wire

[rtl/mm4_mac.sv]
// ----------------------------------------------------------------------------
// mm4_mac
// Shared multiply-accumulate unit: registered 32x32 multiply, full-width
// accumulate, then arithmetic shift and saturation into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_mac #(
   parameter int DIM       = mm4_pkg::DIM_DEFAULT,
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire mm4_pkg::tag_type          tag_issue,
   input  wire logic [mm4_pkg::ELEM_W-1:0] a_data,
   input  wire logic [mm4_pkg::ELEM_W-1:0] b_data,
   output logic                           rsp_valid,
   output mm4_pkg::rsp_type               rsp_item
);
   import mm4_pkg::*;

   localparam int ACC_W = PROD_W + $clog2(DIM);

   tag_type tag_rd_ff, tag_mul_ff, tag_acc_ff;

   logic signed [ELEM_W-1:0] a_s, b_s;
   logic signed [PROD_W-1:0] prod_in, prod_ff;
   logic signed [ACC_W-1:0]  acc_in, acc_ff, prod_ext, shifted;
   logic [ACC_W-32:0]        top_bits;
   logic signed [ELEM_W-1:0] sat_value;
   logic                     rsp_valid_in, rsp_valid_ff;
   rsp_type                  rsp_in, rsp_ff;

   // tag pipeline lines up with read data, product and accumulator
   always_ff @(posedge clock) begin
      if (reset) begin
         tag_rd_ff  <= '0;
         tag_mul_ff <= '0;
         tag_acc_ff <= '0;
      end else begin
         tag_rd_ff  <= tag_issue;
         tag_mul_ff <= tag_rd_ff;
         tag_acc_ff <= tag_mul_ff;
      end
   end

   always_comb begin
      a_s      = signed'(a_data);
      b_s      = signed'(b_data);
      prod_in  = a_s * b_s;
      prod_ext = {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      acc_in   = tag_mul_ff.first ? prod_ext : acc_ff + prod_ext;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag_mul_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   // floor shift, then clamp to the 32-bit signed range
   always_comb begin
      shifted  = acc_ff >>> FRAC_BITS;
      top_bits = shifted[ACC_W-1:31];
      if ((&top_bits) || !(|top_bits)) begin
         sat_value = shifted[ELEM_W-1:0];
      end else if (shifted[ACC_W-1]) begin
         sat_value = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(ELEM_W-1){1'b1}}};
      end
      rsp_valid_in          = tag_acc_ff.valid && tag_acc_ff.acc_end;
      rsp_in.out_row        = tag_acc_ff.row;
      rsp_in.out_col        = tag_acc_ff.col;
      rsp_in.product_value  = sat_value;
      rsp_in.last_out       = tag_acc_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

[rtl/mm4_ctrl.sv]
// ----------------------------------------------------------------------------
// mm4_ctrl
// Sequencer: takes element loads, and on go walks row, column and inner
// index, issuing one store read pair per cycle to the shared MAC.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_ctrl #(
   parameter int DIM    = mm4_pkg::DIM_DEFAULT,
   parameter int ADDR_W = $clog2(DIM * DIM)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire mm4_pkg::req_type req_item,
   input  wire logic             rsp_valid,
   input  wire logic             rsp_last,
   output logic                  busy,
   output logic                  wr_en,
   output logic [ADDR_W-1:0]     wr_addr,
   output logic [ADDR_W-1:0]     rd_a_addr,
   output logic [ADDR_W-1:0]     rd_b_addr,
   output mm4_pkg::tag_type      tag_issue
);
   import mm4_pkg::*;

   localparam int          IDX_W = $clog2(DIM);
   localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(DIM - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic             accept, final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      busy       = (state_ff != ST_IDLE);
      accept     = start && !busy;
      final_beat = (i_ff == IDX_MAX) && (j_ff == IDX_MAX) && (k_ff == IDX_MAX);

      wr_en   = accept && (32'(req_item.load_row) < DIM) && (32'(req_item.load_col) < DIM);
      wr_addr = ADDR_W'(32'(req_item.load_row) * DIM + 32'(req_item.load_col));

      rd_a_addr = ADDR_W'(32'(i_ff) * DIM + 32'(k_ff));
      rd_b_addr = ADDR_W'(32'(k_ff) * DIM + 32'(j_ff));

      tag_issue.valid   = (state_ff == ST_ISSUE);
      tag_issue.first   = (k_ff == '0);
      tag_issue.acc_end = (k_ff == IDX_MAX);
      tag_issue.last    = final_beat;
      tag_issue.row     = IDX_FIELD_W'(i_ff);
      tag_issue.col     = IDX_FIELD_W'(j_ff);

      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept && req_item.go) begin
               state_in = ST_ISSUE;
               i_in     = '0;
               j_in     = '0;
               k_in     = '0;
            end
         end
         ST_ISSUE: begin
            if (final_beat) begin
               state_in = ST_DRAIN;
            end else if (k_ff != IDX_MAX) begin
               k_in = k_ff + 1'b1;
            end else begin
               k_in = '0;
               if (j_ff != IDX_MAX) begin
                  j_in = j_ff + 1'b1;
               end else begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end
            end
         end
         ST_DRAIN: begin
            if (rsp_valid && rsp_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

[rtl/mm4_checker.sv]
// ----------------------------------------------------------------------------
// mm4_checker
// Port-level checks of the multiply block's busy and result timing.
// ----------------------------------------------------------------------------
`default_nettype none

module mm4_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             start,
   input wire mm4_pkg::req_type req_item,
   input wire logic             busy,
   input wire logic             rsp_valid,
   input wire mm4_pkg::rsp_type rsp_item
);
   import mm4_pkg::*;

   // results only come out of a running multiply
   a_rsp_in_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("result beat while not busy");

   a_go_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.go) |=> busy)
      else $error("go beat did not start a multiply");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_item.go) |=> !busy)
      else $error("plain load left the block busy");

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.last_out) |=> !busy)
      else $error("busy held after the final result");

   // result beats never come back to back
   a_rsp_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result beats back to back");

endmodule

bind matrix4x4_multiply mm4_checker u_mm4_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .req_item  (req_item),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire
